// ===== sv/utv_pkg.sv =====
`timescale 1ns / 1ps
// utv_pkg: types and constants shared by the utf-8 text validator
// no dependencies

package utv_pkg;

  localparam int unsigned CodeW = 21;

  // lead byte limits
  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] AsciiMax    = 8'h7F;

  // code point limits
  localparam logic [CodeW-1:0] MinTwo       = 21'h00080;
  localparam logic [CodeW-1:0] MinThree     = 21'h00800;
  localparam logic [CodeW-1:0] MinFour      = 21'h10000;
  localparam logic [CodeW-1:0] MaxCode      = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrogateLo  = 21'h0D800;
  localparam logic [CodeW-1:0] SurrogateHi  = 21'h0DFFF;
  localparam logic [CodeW-1:0] C0Max        = 21'h0001F;
  localparam logic [CodeW-1:0] DelCode      = 21'h0007F;
  localparam logic [CodeW-1:0] C1Lo         = 21'h00080;
  localparam logic [CodeW-1:0] C1Hi         = 21'h0009F;

  // continuation counts
  localparam logic [1:0] ContNone  = 2'd0;
  localparam logic [1:0] ContOne   = 2'd1;
  localparam logic [1:0] ContTwo   = 2'd2;
  localparam logic [1:0] ContThree = 2'd3;

  typedef struct packed {
    logic [1:0]       bytes_pending;
    logic [1:0]       sequence_length;
    logic [CodeW-1:0] code_accumulator;
    logic             error_seen;
  } dec_state_t;

  localparam dec_state_t DecStateClear = '{
    bytes_pending:    ContNone,
    sequence_length:  ContNone,
    code_accumulator: '0,
    error_seen:       1'b0
  };

endpackage

// ===== sv/utv_if.sv =====
`timescale 1ns / 1ps
// utv_byte_if and utv_verdict_if: valid/ready channels of the validator
// no dependencies

interface utv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface utv_verdict_if;
  logic valid;
  logic ready;
  logic text_valid;
  logic string_end;

  modport source (output valid, output text_valid, output string_end, input ready);
  modport sink   (input valid, input text_valid, input string_end, output ready);
endinterface

// ===== sv/utv_step.sv =====
`timescale 1ns / 1ps
// utv_step: next decoder state and running verdict for one byte
// depends on utv_pkg

module utv_step (
  input  utv_pkg::dec_state_t state_i,
  input  logic [7:0]          text_byte_i,
  input  logic                final_byte_i,
  output utv_pkg::dec_state_t state_o,
  output logic                text_valid_o
);

  function automatic logic point_rejected(logic [utv_pkg::CodeW-1:0] cp, logic [1:0] cont);
    logic rej;
    rej = 1'b0;
    if (cont == utv_pkg::ContOne   && cp < utv_pkg::MinTwo)   rej = 1'b1;
    if (cont == utv_pkg::ContTwo   && cp < utv_pkg::MinThree) rej = 1'b1;
    if (cont == utv_pkg::ContThree && cp < utv_pkg::MinFour)  rej = 1'b1;
    if (cp > utv_pkg::MaxCode) rej = 1'b1;
    if (cp >= utv_pkg::SurrogateLo && cp <= utv_pkg::SurrogateHi) rej = 1'b1;
    if (cp <= utv_pkg::C0Max || cp == utv_pkg::DelCode) rej = 1'b1;
    if (cp >= utv_pkg::C1Lo && cp <= utv_pkg::C1Hi) rej = 1'b1;
    return rej;
  endfunction

  utv_pkg::dec_state_t         nxt;
  logic [utv_pkg::CodeW-1:0]   acc_shift;
  logic                        err;
  logic [1:0]                  pend_dec;

  assign acc_shift = {state_i.code_accumulator[utv_pkg::CodeW-7:0], text_byte_i[5:0]};
  assign pend_dec  = state_i.bytes_pending - 2'd1;

  always_comb begin
    nxt = state_i;
    err = 1'b0;
    if (!state_i.error_seen) begin
      if (state_i.bytes_pending == utv_pkg::ContNone) begin
        if (text_byte_i <= utv_pkg::AsciiMax) begin
          err = point_rejected({13'd0, text_byte_i}, utv_pkg::ContNone);
        end else if (text_byte_i >= utv_pkg::LeadTwoLo && text_byte_i <= utv_pkg::LeadTwoHi) begin
          nxt.code_accumulator = {16'd0, text_byte_i[4:0]};
          nxt.sequence_length  = utv_pkg::ContOne;
          nxt.bytes_pending    = utv_pkg::ContOne;
        end else if (text_byte_i >= utv_pkg::LeadThreeLo &&
                     text_byte_i <= utv_pkg::LeadThreeHi) begin
          nxt.code_accumulator = {17'd0, text_byte_i[3:0]};
          nxt.sequence_length  = utv_pkg::ContTwo;
          nxt.bytes_pending    = utv_pkg::ContTwo;
        end else if (text_byte_i >= utv_pkg::LeadFourLo && text_byte_i <= utv_pkg::LeadFourHi) begin
          nxt.code_accumulator = {18'd0, text_byte_i[2:0]};
          nxt.sequence_length  = utv_pkg::ContThree;
          nxt.bytes_pending    = utv_pkg::ContThree;
        end else begin
          err = 1'b1;
        end
      end else if (text_byte_i[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        nxt.code_accumulator = acc_shift;
        nxt.bytes_pending    = pend_dec;
        // last continuation: check the whole code point
        if (pend_dec == utv_pkg::ContNone) begin
          if (point_rejected(acc_shift, state_i.sequence_length)) begin
            err = 1'b1;
          end else begin
            nxt.sequence_length  = utv_pkg::ContNone;
            nxt.code_accumulator = '0;
          end
        end
      end
    end
    if (err) begin
      nxt = utv_pkg::DecStateClear;
      nxt.error_seen = 1'b1;
    end

    text_valid_o = !nxt.error_seen;
    if (final_byte_i) begin
      // an open sequence at the end fails the string
      if (nxt.bytes_pending != utv_pkg::ContNone) text_valid_o = 1'b0;
      state_o = utv_pkg::DecStateClear;
    end else begin
      state_o = nxt;
    end
  end

endmodule

// ===== sv/utf8_text_validator.sv =====
`timescale 1ns / 1ps
// utf8_text_validator: top level, input register, decoder state, result register
// depends on utv_pkg, utv_if, utv_step

// Checks a byte string for well-formed utf-8 in a restricted character set, one
// byte per transfer, and returns one verdict per byte. A string ends at the byte
// with final_byte set; its verdict is then complete and all state clears. The
// block takes one byte every clock while the result side keeps ready high: a byte
// is registered on input, decoded combinationally against the held state, and
// its verdict lands in the result register, from which it is offered. Both
// registers stall only when the result side holds off ready.

module utf8_text_validator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  utv_byte_if.sink             in_i,
  utv_verdict_if.source        out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;

  logic       out_valid_q;
  logic       out_text_valid_q;
  logic       out_end_q;

  utv_pkg::dec_state_t state_q, state_d;
  logic                verdict;
  logic                out_free;
  logic                advance;

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  utv_step u_step (
    .state_i      (state_q),
    .text_byte_i  (in_byte_q),
    .final_byte_i (in_final_q),
    .state_o      (state_d),
    .text_valid_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= utv_pkg::DecStateClear;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (out_free)   out_valid_q <= in_valid_q;
      if (advance)    state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.text_byte;
      in_final_q <= in_i.final_byte;
    end
    if (advance) begin
      out_text_valid_q <= verdict;
      out_end_q        <= in_final_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.text_valid = out_text_valid_q;
  assign out_o.string_end = out_end_q;

endmodule

// ===== verif/utv_verdict_check.sv =====
`timescale 1ns / 1ps
// utv_verdict_check: watches both channels of the utf-8 text validator, predicts
// each byte's verdict and compares it with what the block returns
// depends on utv_pkg and utv_if

module utv_verdict_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  utv_byte_if         byte_i,
  utv_verdict_if      verdict_i,
  output int unsigned fail_count_o,
  output int unsigned verdicts_due_o
);

  typedef struct packed {
    logic text_valid;
    logic string_end;
  } verdict_t;

  localparam utv_pkg::dec_state_t DecStateError = '{
    bytes_pending:    utv_pkg::ContNone,
    sequence_length:  utv_pkg::ContNone,
    code_accumulator: '0,
    error_seen:       1'b1
  };

  verdict_t            verdicts_due[$];
  utv_pkg::dec_state_t dec = utv_pkg::DecStateClear;
  int unsigned         fails = 0;
  int unsigned         verdicts_seen = 0;

  function automatic logic code_rejected(logic [utv_pkg::CodeW-1:0] cp, logic [1:0] cont);
    return (cont == utv_pkg::ContOne   && cp < utv_pkg::MinTwo)   ||
           (cont == utv_pkg::ContTwo   && cp < utv_pkg::MinThree) ||
           (cont == utv_pkg::ContThree && cp < utv_pkg::MinFour)  ||
           (cp > utv_pkg::MaxCode)                                ||
           (cp >= utv_pkg::SurrogateLo && cp <= utv_pkg::SurrogateHi) ||
           (cp <= utv_pkg::C0Max) || (cp == utv_pkg::DelCode)     ||
           (cp >= utv_pkg::C1Lo && cp <= utv_pkg::C1Hi);
  endfunction

  // next decoder state after one byte; bytes after an error change nothing
  function automatic utv_pkg::dec_state_t decode_byte(utv_pkg::dec_state_t cur,
                                                      logic [7:0] b);
    utv_pkg::dec_state_t nxt;
    nxt = cur;
    if (cur.error_seen) return nxt;
    if (cur.bytes_pending == utv_pkg::ContNone) begin
      if (b <= utv_pkg::AsciiMax) begin
        if (code_rejected(utv_pkg::CodeW'(b), utv_pkg::ContNone)) nxt = DecStateError;
      end else if (b >= utv_pkg::LeadTwoLo && b <= utv_pkg::LeadTwoHi) begin
        nxt.code_accumulator = utv_pkg::CodeW'(b[4:0]);
        nxt.sequence_length  = utv_pkg::ContOne;
        nxt.bytes_pending    = utv_pkg::ContOne;
      end else if (b >= utv_pkg::LeadThreeLo && b <= utv_pkg::LeadThreeHi) begin
        nxt.code_accumulator = utv_pkg::CodeW'(b[3:0]);
        nxt.sequence_length  = utv_pkg::ContTwo;
        nxt.bytes_pending    = utv_pkg::ContTwo;
      end else if (b >= utv_pkg::LeadFourLo && b <= utv_pkg::LeadFourHi) begin
        nxt.code_accumulator = utv_pkg::CodeW'(b[2:0]);
        nxt.sequence_length  = utv_pkg::ContThree;
        nxt.bytes_pending    = utv_pkg::ContThree;
      end else begin
        nxt = DecStateError;
      end
    end else if (b[7:6] != 2'b10) begin
      nxt = DecStateError;
    end else begin
      nxt.code_accumulator = {cur.code_accumulator[utv_pkg::CodeW-7:0], b[5:0]};
      nxt.bytes_pending    = cur.bytes_pending - 2'd1;
      if (nxt.bytes_pending == utv_pkg::ContNone) begin
        if (code_rejected(nxt.code_accumulator, cur.sequence_length)) begin
          nxt = DecStateError;
        end else begin
          nxt.sequence_length  = utv_pkg::ContNone;
          nxt.code_accumulator = '0;
        end
      end
    end
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t            got;
    verdict_t            want;
    utv_pkg::dec_state_t nxt;
    if (!rst_ni) begin
      dec = utv_pkg::DecStateClear;
      verdicts_due.delete();
    end else begin
      // a verdict cannot belong to a byte taken at the same edge, so check first
      if (verdict_i.valid && verdict_i.ready) begin
        got = '{text_valid: verdict_i.text_valid, string_end: verdict_i.string_end};
        if (verdicts_due.size() == 0) begin
          $error("verdict %0d with no byte waiting: text_valid=%0b string_end=%0b",
                 verdicts_seen, got.text_valid, got.string_end);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.text_valid !== want.text_valid) begin
            $error("verdict %0d text_valid: expected %0b, actual %0b",
                   verdicts_seen, want.text_valid, got.text_valid);
            fails++;
          end
          if (got.string_end !== want.string_end) begin
            $error("verdict %0d string_end: expected %0b, actual %0b",
                   verdicts_seen, want.string_end, got.string_end);
            fails++;
          end
        end
        verdicts_seen++;
      end
      if (byte_i.valid && byte_i.ready) begin
        nxt = decode_byte(dec, byte_i.text_byte);
        want.text_valid = !nxt.error_seen;
        want.string_end = byte_i.final_byte;
        if (byte_i.final_byte) begin
          // a sequence still open at the end fails the string
          if (nxt.bytes_pending != utv_pkg::ContNone) want.text_valid = 1'b0;
          nxt = utv_pkg::DecStateClear;
        end
        dec = nxt;
        verdicts_due.push_back(want);
      end
    end
    fail_count_o   <= fails;
    verdicts_due_o <= verdicts_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: byte stimulus, result back-pressure and verdict for the utf-8 validator
// depends on utv_pkg, utv_if, utf8_text_validator and utv_verdict_check

module testbench;

  localparam int unsigned ByteTarget    = 750;
  localparam int unsigned TailBytes     = 120;
  localparam int unsigned HoldBytes     = 30;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 1000;

  logic clk_i = 1'b0;
  logic rst_ni;

  utv_byte_if    byte_if ();
  utv_verdict_if verdict_if ();

  int unsigned fail_count;
  int unsigned verdicts_due;
  int unsigned hold_requests = 0;
  logic        quiet_tail = 1'b0;
  logic        steady_sender = 1'b0;
  int unsigned calm_bytes = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  text_q[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  utf8_text_validator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (verdict_if)
  );

  utv_verdict_check verdict_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_if),
    .verdict_i      (verdict_if),
    .fail_count_o   (fail_count),
    .verdicts_due_o (verdicts_due)
  );

  // offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady_sender && calm_bytes == 0 && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    if (calm_bytes != 0) calm_bytes--;
    else if ($urandom_range(0, 24) == 0) calm_bytes = $urandom_range(15, 50);
    byte_if.valid      <= 1'b1;
    byte_if.text_byte  <= b;
    byte_if.final_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // directed string, first byte in the top used byte of packed_bytes
  task automatic send_word(input logic [31:0] packed_bytes, input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      text_q.push_back(packed_bytes[8*(count-1-k) +: 8]);
    end
    send_text();
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic drain_verdicts();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdicts_due != 0);
  endtask

  // encode a code point in len bytes, now and then cut short
  function automatic void push_code(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: text_q.push_back(cp[7:0]);
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
    if (len > 1 && $urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
    end
  endfunction

  // mostly legal characters, with overlongs, surrogates, out of range and noise
  function automatic void add_char();
    int unsigned pick;
    int unsigned odd;
    pick = $urandom_range(0, 99);
    odd  = $urandom_range(0, 15);
    if (pick < 3) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      push_code(odd == 0 ? 21'($urandom_range(0, 'h7F)) : 21'($urandom_range('h20, 'h7E)), 1);
    end else if (pick < 65) begin
      push_code(odd == 0 ? 21'($urandom_range(0, 'h7F)) : 21'($urandom_range('h80, 'h7FF)), 2);
    end else if (pick < 85) begin
      push_code(odd == 0 ? 21'($urandom_range(0, 'h7FF)) :
                odd == 1 ? 21'($urandom_range('hD800, 'hDFFF)) :
                           21'($urandom_range('h800, 'hFFFF)), 3);
    end else begin
      push_code(odd == 0 ? 21'($urandom_range(0, 'hFFFF)) :
                odd == 1 ? 21'($urandom_range('h110000, 'h1FFFFF)) :
                           21'($urandom_range('h10000, 'h10FFFF)), 4);
    end
  endfunction

  task automatic random_string();
    int unsigned chars;
    chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    repeat (chars) add_char();
    send_text();
  endtask

  // result side: short random stalls, calm stretches, one long hold on request
  initial begin : verdict_sink
    int unsigned served;
    int unsigned calm_cycles;
    served      = 0;
    calm_cycles = 0;
    verdict_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_requests != served) begin
        served = hold_requests;
        verdict_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        verdict_if.ready <= 1'b1;
      end else if (!quiet_tail && calm_cycles == 0 && $urandom_range(0, 5) == 0) begin
        verdict_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        verdict_if.ready <= 1'b1;
      end else begin
        verdict_if.ready <= 1'b1;
        if (calm_cycles != 0) calm_cycles--;
        else if ($urandom_range(0, 30) == 0) calm_cycles = $urandom_range(20, 80);
      end
    end
  end

  // watchdog: cycles in a row with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) ||
        (verdict_if.valid && verdict_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned hold_start;
    byte_if.valid      <= 1'b0;
    byte_if.text_byte  <= 8'h00;
    byte_if.final_byte <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single bytes at and beyond the edges of the printable range and an illegal lead
    send_word(32'h20, 1);
    send_word(32'h7E, 1);
    send_word(32'h00, 1);
    send_word(32'h1F, 1);
    send_word(32'h7F, 1);
    send_word(32'hFF, 1);
    // two byte: legal, c1 control, bad continuation
    send_word(32'hC2A0, 2);
    send_word(32'hC29F, 2);
    send_word(32'hC241, 2);
    // overlong three byte, surrogate, above the top code point
    send_word(32'hE08080, 3);
    send_word(32'hEDA080, 3);
    send_word(32'hF4908080, 4);
    // sequence left open at the end, bytes after a stray continuation
    send_word(32'hC3, 1);
    send_word(32'h8041, 2);
    drain_verdicts();

    while (bytes_sent < ByteTarget) begin
      if (hold_requests == 0 && bytes_sent >= ByteTarget / 3) begin
        // keep offering while the result side holds off, so the block backs up
        steady_sender = 1'b1;
        hold_requests <= hold_requests + 1;
        hold_start = bytes_sent;
        while (bytes_sent < hold_start + HoldBytes) random_string();
        steady_sender = 1'b0;
        drain_verdicts();
      end
      if (!quiet_tail && bytes_sent >= ByteTarget - TailBytes) begin
        quiet_tail    <= 1'b1;
        steady_sender = 1'b1;
      end
      random_string();
    end

    drain_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
